>>> hw/rtl/encoder_straight_drive_balancer_unit_defines.svh
// ---------------------------------------------------------------------------
// Straight-drive balancer assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and held off
// during reset.
// ---------------------------------------------------------------------------
`ifndef ENCODER_STRAIGHT_DRIVE_BALANCER_UNIT_DEFINES_SVH
`define ENCODER_STRAIGHT_DRIVE_BALANCER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define ESDB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ESDB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/esdb_pkg.sv
// ---------------------------------------------------------------------------
// esdb_pkg
// Widths, codes, shared types and helper functions of the balancer.
// ---------------------------------------------------------------------------
package esdb_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int THR_W       = 12;
    localparam int CMP_W       = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
    localparam int DIST_W      = 16;
    localparam int TIME_W      = 32;
    localparam int CNT_W       = 16;
    localparam int WIN_W       = 8;
    localparam int PWR_W       = 7;
    localparam int DRV_W       = 8;
    localparam int PROD_W      = 32;

    localparam int IN_RAW_W    = DIST_W + 2 * SAMPLE_BITS + TIME_W;
    localparam int IN_DATA_W   = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W   = 5 + 2 * DRV_W;
    localparam int OUT_DATA_W  = ((OUT_RAW_W + 7) / 8) * 8;

    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = APB_ADDR_W - 2;

    localparam int DIV_STEPS   = PROD_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_ONES = '1;
    localparam logic [CMP_W-1:0] SAMPLE_MASK = CMP_W'(SAMPLE_ONES);

    localparam logic [DIST_W-1:0] MIN_DIST        = DIST_W'(10);
    localparam logic [PWR_W-1:0]  SPEED_OFFSET    = PWR_W'(5);
    localparam logic [PWR_W-1:0]  MIN_SLAVE_POWER = PWR_W'(10);

    // Item kinds
    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_ADC_THRESHOLD  = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_MASTER_SPEED   = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_STOP_MARGIN    = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_COUNTS_PER_REV = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_CIRCUMFERENCE  = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_UPDATE_INTERVAL = REG_IDX_W'(5);

    typedef struct packed {
        logic [THR_W-1:0]  adc_threshold;
        logic [PWR_W-1:0]  master_speed;
        logic [DIST_W-1:0] stopping_margin;
        logic [CNT_W-1:0]  counts_per_turn;
        logic [CNT_W-1:0]  rev_distance;
        logic [TIME_W-1:0] update_interval_us;
    } t_esdb_cfg;

    typedef struct packed {
        logic take_start;
        logic take_sample;
        logic div_init;
        logic div_step;
        logic tgt_load;
        logic tgt_zero;
    } t_esdb_cmd;

    typedef struct packed {
        logic span_ok;
    } t_esdb_sts;

    // Last member sits in the lowest bits.
    typedef struct packed {
        logic             done_res;
        logic             slave_brake;
        logic             master_brake;
        logic [DRV_W-1:0] slave_drive;
        logic             slave_speed_set;
        logic [DRV_W-1:0] master_drive;
        logic             master_speed_set;
    } t_esdb_result;

    function automatic logic sample_high(input logic [SAMPLE_BITS-1:0] rd,
                                         input logic [THR_W-1:0] thr);
        logic [CMP_W-1:0] rd_x;
        logic [CMP_W-1:0] thr_x;
        rd_x  = CMP_W'(rd);
        thr_x = CMP_W'(thr) & SAMPLE_MASK;
        return rd_x > thr_x;
    endfunction

    function automatic logic [DRV_W-1:0] neg_drive(input logic [PWR_W-1:0] pwr);
        return DRV_W'(0) - DRV_W'(pwr);
    endfunction

endpackage

>>> hw/rtl/esdb_regs.sv
// ---------------------------------------------------------------------------
// esdb_regs
// Configuration register file behind the APB-style port.
// ---------------------------------------------------------------------------
module esdb_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [esdb_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [esdb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [esdb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output esdb_pkg::t_esdb_cfg              o_cfg
);
    import esdb_pkg::*;

    t_esdb_cfg              r_cfg;
    logic                   wr_en;
    logic [REG_IDX_W-1:0]   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.adc_threshold       <= THR_W'(2048);
            r_cfg.master_speed        <= PWR_W'(60);
            r_cfg.stopping_margin     <= '0;
            r_cfg.counts_per_turn     <= CNT_W'(800);
            r_cfg.rev_distance        <= CNT_W'(200);
            r_cfg.update_interval_us  <= TIME_W'(100000);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ADC_THRESHOLD:   r_cfg.adc_threshold       <= pwdata[THR_W-1:0];
                REG_MASTER_SPEED:    r_cfg.master_speed        <= pwdata[PWR_W-1:0];
                REG_STOP_MARGIN:     r_cfg.stopping_margin     <= pwdata[DIST_W-1:0];
                REG_COUNTS_PER_REV:  r_cfg.counts_per_turn     <= pwdata[CNT_W-1:0];
                REG_CIRCUMFERENCE:   r_cfg.rev_distance        <= pwdata[CNT_W-1:0];
                REG_UPDATE_INTERVAL: r_cfg.update_interval_us  <= pwdata[TIME_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ADC_THRESHOLD:   prdata = APB_DATA_W'(r_cfg.adc_threshold);
            REG_MASTER_SPEED:    prdata = APB_DATA_W'(r_cfg.master_speed);
            REG_STOP_MARGIN:     prdata = APB_DATA_W'(r_cfg.stopping_margin);
            REG_COUNTS_PER_REV:  prdata = APB_DATA_W'(r_cfg.counts_per_turn);
            REG_CIRCUMFERENCE:   prdata = APB_DATA_W'(r_cfg.rev_distance);
            REG_UPDATE_INTERVAL: prdata = APB_DATA_W'(r_cfg.update_interval_us);
            default:             prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/esdb_div.sv
// ---------------------------------------------------------------------------
// esdb_div
// Restoring divider, one quotient bit per step.
// ---------------------------------------------------------------------------
module esdb_div (
    input  logic                          i_clk,
    input  logic                          i_init,
    input  logic                          i_step,
    input  logic [esdb_pkg::PROD_W-1:0]   i_dividend,
    input  logic [esdb_pkg::CNT_W-1:0]    i_divisor,
    output logic [esdb_pkg::PROD_W-1:0]   o_quotient
);
    import esdb_pkg::*;

    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [PROD_W-1:0] r_quo;
    logic [CNT_W:0]    trial;
    logic              fits;

    // A zero divisor always fits, giving an all-ones quotient.
    assign trial      = {r_rem, r_quo[PROD_W-1]};
    assign fits       = trial >= {1'b0, r_div};
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (i_step) begin
            r_rem <= fits ? CNT_W'(trial - {1'b0, r_div}) : trial[CNT_W-1:0];
            r_quo <= {r_quo[PROD_W-2:0], fits};
        end
    end

endmodule

>>> hw/rtl/esdb_dp.sv
// ---------------------------------------------------------------------------
// esdb_dp
// Datapath: edge counting, braking, slave power correction, target setup.
// ---------------------------------------------------------------------------
module esdb_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  esdb_pkg::t_esdb_cmd              i_cmd,
    input  esdb_pkg::t_esdb_cfg              i_cfg,
    input  logic [esdb_pkg::IN_DATA_W-1:0]   i_tdata,
    output esdb_pkg::t_esdb_sts              o_sts,
    output logic [esdb_pkg::OUT_DATA_W-1:0]  o_tdata
);
    import esdb_pkg::*;

    localparam int SUM_W = WIN_W + 2;
    localparam logic signed [SUM_W-1:0] PWR_MAX = SUM_W'((1 << PWR_W) - 1);

    logic [DIST_W-1:0]      in_dist;
    logic [SAMPLE_BITS-1:0] in_enc_a;
    logic [SAMPLE_BITS-1:0] in_enc_b;
    logic [TIME_W-1:0]      in_now;

    logic                   r_moving, n_moving;
    logic                   r_m_prev, n_m_prev;
    logic                   r_s_prev, n_s_prev;
    logic [WIN_W-1:0]       r_m_win, n_m_win;
    logic [WIN_W-1:0]       r_s_win, n_s_win;
    logic [CNT_W-1:0]       r_m_tot, n_m_tot;
    logic [CNT_W-1:0]       r_s_tot, n_s_tot;
    logic [CNT_W-1:0]       r_target;
    logic [PWR_W-1:0]       r_power, n_power;
    logic [TIME_W-1:0]      r_last, n_last;
    logic [DIST_W-1:0]      r_span;
    logic                   r_span_ok;
    t_esdb_result           r_out, n_out;

    logic                   m_high, s_high, m_rise, s_rise;
    logic [WIN_W-1:0]       m_win_upd, s_win_upd;
    logic [CNT_W-1:0]       m_tot_upd, s_tot_upd;
    logic                   s_behind;
    logic [PWR_W-1:0]       pwr_floor;
    logic [PWR_W-1:0]       pwr_start;
    logic [TIME_W-1:0]      elapsed;
    logic                   corr_due;
    logic signed [WIN_W:0]  win_diff;
    logic signed [WIN_W:0]  win_half;
    logic signed [SUM_W-1:0] pwr_sum;
    logic [PWR_W-1:0]       pwr_corr;
    logic                   done;
    logic [PROD_W-1:0]      product;
    logic [PROD_W-1:0]      quotient;

    assign in_dist  = i_tdata[DIST_W-1:0];
    assign in_enc_a = i_tdata[DIST_W +: SAMPLE_BITS];
    assign in_enc_b = i_tdata[DIST_W + SAMPLE_BITS +: SAMPLE_BITS];
    assign in_now   = i_tdata[DIST_W + 2 * SAMPLE_BITS +: TIME_W];

    // Edge detection and counting
    assign m_high    = sample_high(in_enc_a, i_cfg.adc_threshold);
    assign s_high    = sample_high(in_enc_b, i_cfg.adc_threshold);
    assign m_rise    = m_high & ~r_m_prev;
    assign s_rise    = s_high & ~r_s_prev;
    assign m_win_upd = r_m_win + WIN_W'(m_rise);
    assign s_win_upd = r_s_win + WIN_W'(s_rise);
    assign m_tot_upd = (m_rise && (r_m_tot != '1)) ? r_m_tot + CNT_W'(1) : r_m_tot;
    assign s_tot_upd = (s_rise && (r_s_tot != '1)) ? r_s_tot + CNT_W'(1) : r_s_tot;

    assign s_behind  = s_tot_upd < r_target;
    assign pwr_floor = (s_behind && (r_power < MIN_SLAVE_POWER)) ? MIN_SLAVE_POWER : r_power;

    // Proportional correction: half the window difference, rounded toward zero
    assign elapsed  = in_now - r_last;
    assign corr_due = elapsed > i_cfg.update_interval_us;
    assign win_diff = $signed({1'b0, m_win_upd}) - $signed({1'b0, s_win_upd});
    assign win_half = (win_diff + $signed({{WIN_W{1'b0}}, win_diff[WIN_W]})) >>> 1;
    assign pwr_sum  = $signed(SUM_W'(pwr_floor)) + SUM_W'(win_half);

    always_comb begin
        priority if (pwr_sum < 0) begin
            pwr_corr = '0;
        end else if (pwr_sum > PWR_MAX) begin
            pwr_corr = PWR_MAX[PWR_W-1:0];
        end else begin
            pwr_corr = pwr_sum[PWR_W-1:0];
        end
    end

    assign done      = (m_tot_upd > r_target) && (s_tot_upd > r_target);
    assign pwr_start = (i_cfg.master_speed >= SPEED_OFFSET) ?
                       i_cfg.master_speed - SPEED_OFFSET : '0;

    always_comb begin
        n_moving = r_moving;
        n_m_prev = r_m_prev;
        n_s_prev = r_s_prev;
        n_m_win  = r_m_win;
        n_s_win  = r_s_win;
        n_m_tot  = r_m_tot;
        n_s_tot  = r_s_tot;
        n_power  = r_power;
        n_last   = r_last;
        n_out    = '0;
        if (i_cmd.take_start) begin
            n_moving = 1'b1;
            n_m_prev = 1'b0;
            n_s_prev = 1'b0;
            n_m_win  = '0;
            n_s_win  = '0;
            n_m_tot  = '0;
            n_s_tot  = '0;
            n_power  = pwr_start;
            n_last   = in_now;
            n_out.master_speed_set = 1'b1;
            n_out.master_drive     = neg_drive(i_cfg.master_speed);
            n_out.slave_speed_set  = 1'b1;
            n_out.slave_drive      = neg_drive(pwr_start);
        end else if (i_cmd.take_sample && r_moving) begin
            n_m_prev = m_high;
            n_s_prev = s_high;
            n_m_win  = m_win_upd;
            n_s_win  = s_win_upd;
            n_m_tot  = m_tot_upd;
            n_s_tot  = s_tot_upd;
            n_power  = pwr_floor;
            n_out.master_brake = m_tot_upd == r_target;
            n_out.slave_brake  = s_tot_upd == r_target;
            if (s_behind) begin
                n_out.slave_speed_set = 1'b1;
                n_out.slave_drive     = neg_drive(pwr_floor);
            end
            if (corr_due) begin
                n_power = pwr_corr;
                n_m_win = '0;
                n_s_win = '0;
                n_last  = in_now;
            end
            if (done) begin
                n_moving       = 1'b0;
                n_out.done_res = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_moving <= 1'b0;
            r_m_prev <= 1'b0;
            r_s_prev <= 1'b0;
            r_m_win  <= '0;
            r_s_win  <= '0;
            r_m_tot  <= '0;
            r_s_tot  <= '0;
            r_power  <= '0;
            r_last   <= '0;
            r_target <= '0;
        end else begin
            r_moving <= n_moving;
            r_m_prev <= n_m_prev;
            r_s_prev <= n_s_prev;
            r_m_win  <= n_m_win;
            r_s_win  <= n_s_win;
            r_m_tot  <= n_m_tot;
            r_s_tot  <= n_s_tot;
            r_power  <= n_power;
            r_last   <= n_last;
            if (i_cmd.tgt_load) begin
                if (i_cmd.tgt_zero) begin
                    r_target <= '0;
                end else if (quotient[PROD_W-1:CNT_W] != '0) begin
                    r_target <= '1;
                end else begin
                    r_target <= quotient[CNT_W-1:0];
                end
            end
        end
    end

    // Payload: start operands and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_start) begin
            r_span    <= in_dist - i_cfg.stopping_margin;
            r_span_ok <= (in_dist >= MIN_DIST) && (in_dist >= i_cfg.stopping_margin);
        end
        if (i_cmd.take_start || i_cmd.take_sample) begin
            r_out <= n_out;
        end
    end

    assign product = PROD_W'(r_span) * PROD_W'(i_cfg.counts_per_turn);

    esdb_div u_div (
        .i_clk      (i_clk),
        .i_init     (i_cmd.div_init),
        .i_step     (i_cmd.div_step),
        .i_dividend (product),
        .i_divisor  (i_cfg.rev_distance),
        .o_quotient (quotient)
    );

    assign o_sts.span_ok = r_span_ok;
    assign o_tdata       = OUT_DATA_W'(r_out);

endmodule

>>> hw/rtl/esdb_ctrl.sv
// ---------------------------------------------------------------------------
// esdb_ctrl
// Controller: handshakes, output register occupancy, target setup sequence.
// ---------------------------------------------------------------------------
module esdb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_op,
    input  logic                 i_m_tready,
    input  esdb_pkg::t_esdb_sts  i_sts,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid,
    output esdb_pkg::t_esdb_cmd  o_cmd
);
    import esdb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic                 s_ready;
    logic                 fire;

    assign s_ready = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign fire    = i_s_tvalid && s_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.take_start  = fire && (i_s_op == OP_START);
        o_cmd.take_sample = fire && (i_s_op == OP_SAMPLE);
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.take_start) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (i_sts.span_ok) begin
                    o_cmd.div_init = 1'b1;
                    n_cnt          = '0;
                    n_state        = ST_DIV;
                end else begin
                    o_cmd.tgt_load = 1'b1;
                    o_cmd.tgt_zero = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_FIN;
                end else begin
                    n_cnt = r_cnt + DIV_CNT_W'(1);
                end
            end
            ST_FIN: begin
                o_cmd.tgt_load = 1'b1;
                n_state        = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        priority if (fire) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = s_ready;
    assign o_m_tvalid = r_out_valid;

endmodule

>>> hw/rtl/encoder_straight_drive_balancer_unit.sv
// ---------------------------------------------------------------------------
// encoder_straight_drive_balancer_unit
// Two-wheel straight drive: target edge count, edge counting, braking and
// proportional slave power correction.
// ---------------------------------------------------------------------------
// Channel  | Direction | Carries
// s_axis   | in        | tuser: op; tdata: distance, enc_a_sample, enc_b_sample, now_us
// m_axis   | out       | tdata: drive, brake and done flags of one result item
// apb      | in/out    | six configuration registers at byte addresses 0x00..0x14
//
// Sample items may follow back to back while results are drained. A start item
// holds the input while the target count is formed: accept, multiply, 32 steps
// of the serial restoring divider if the span is valid, then the target write.
// Every item gives exactly one result, held in an output register; outside target
// setup, the next item is taken in the same cycle the held result is drained.
// Reset is synchronous: all counters clear and registers return to defaults.
// ---------------------------------------------------------------------------
`include "encoder_straight_drive_balancer_unit_defines.svh"

module encoder_straight_drive_balancer_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input items
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [15:0] distance, [27:16] enc_a_sample, [39:28] enc_b_sample, [71:40] now_us
    input  logic [esdb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] op
    input  logic [0:0]                       s_axis_tuser,
    // Result items
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] master_speed_set, [8:1] master_drive, [9] slave_speed_set,
    // [17:10] slave_drive, [18] master_brake, [19] slave_brake, [20] done_res
    output logic [esdb_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // Configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [esdb_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [esdb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [esdb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import esdb_pkg::*;

    t_esdb_cfg cfg;
    t_esdb_cmd cmd;
    t_esdb_sts sts;

    // Register file
    esdb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Controller: owns both handshakes and sequences the divider
    esdb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_op     (s_axis_tuser[0]),
        .i_m_tready (m_axis_tready),
        .i_sts      (sts),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_cmd      (cmd)
    );

    // Datapath: all move state and the result register
    esdb_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_cfg   (cfg),
        .i_tdata (s_axis_tdata),
        .o_sts   (sts),
        .o_tdata (m_axis_tdata)
    );

    // A start item blocks the input while the target is formed
    `ESDB_ASSERT_NEXT(a_start_holds_input, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_START), !s_axis_tready, "input taken during target setup")
    // Every accepted item leaves a result in the output register
    `ESDB_ASSERT_NEXT(a_item_gives_result, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid, "accepted item gave no result")
    // Datapath commands never overlap
    `ESDB_ASSERT_IMP(a_cmd_exclusive, i_clk, i_rst_n, 1'b1, $onehot0({cmd.take_start, cmd.take_sample, cmd.div_init, cmd.div_step, cmd.tgt_load}), "overlapping datapath commands")
    // Division runs only for a distance of at least MIN_DIST and not below the stopping margin
    `ESDB_ASSERT_IMP(a_div_needs_span, i_clk, i_rst_n, cmd.div_init, sts.span_ok, "division started on invalid span")

endmodule

>>> verif/encoder_straight_drive_balancer_unit_test.sv
// ----------------------------------------------------------------------------
// Straight-drive balancer unit test
// Sends start and encoder poll items through the input stream and works out
// each result item from an independent model of the target count, edge
// counting, braking and slave power correction. Every result item is compared
// field by field. Runs directed cases and random moves under several patterns
// of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module encoder_straight_drive_balancer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import esdb_pkg::*;

    // A start item holds the input while the target count is formed. Allow for many
    // such holds, plus long runs of receiver stalls and sender gaps.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 40;
    localparam int MASTER         = 0;
    localparam int SLAVE          = 1;
    // Address past the end of the register list: writes must be ignored.
    localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_IDX_W'(6);

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // [15:0] distance, [27:16] enc_a_sample, [39:28] enc_b_sample, [71:40] now_us
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    // [0] op
    logic [0:0]              s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // [0] master_speed_set, [8:1] master_drive, [9] slave_speed_set,
    // [17:10] slave_drive, [18] master_brake, [19] slave_brake, [20] done_res
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr = '0;
    logic [APB_DATA_W-1:0]   pwdata = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    encoder_straight_drive_balancer_unit uut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Model of the block: configuration copy and move state
    // ------------------------------------------------------------------------
    typedef struct {
        logic             hi;
        logic [WIN_W-1:0] win;
        logic [CNT_W-1:0] tot;
    } t_wheel;

    typedef struct packed {
        logic [REG_IDX_W-1:0]  idx;
        logic [APB_DATA_W-1:0] val;
    } t_reg_write;

    logic [THR_W-1:0]  thr_cfg;
    logic [PWR_W-1:0]  speed_cfg;
    logic [DIST_W-1:0] margin_cfg;
    logic [CNT_W-1:0]  cpr_cfg;
    logic [CNT_W-1:0]  circ_cfg;
    logic [TIME_W-1:0] interval_cfg;

    t_wheel            wheel [2];
    logic              moving_now;
    logic [CNT_W-1:0]  target_edges;
    logic [PWR_W-1:0]  slave_pwr;
    logic [TIME_W-1:0] last_fix_us;

    t_esdb_result      expected_drive_q[$];
    t_reg_write        reg_write_q[$];

    int err_count     = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int moves_done    = 0;
    int fixes_done    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;
    logic [TIME_W-1:0] now_us = '0;

    task automatic reset_model();
        thr_cfg      = THR_W'(2048);
        speed_cfg    = PWR_W'(60);
        margin_cfg   = '0;
        cpr_cfg      = CNT_W'(800);
        circ_cfg     = CNT_W'(200);
        interval_cfg = TIME_W'(100000);
        for (int w = 0; w < 2; w++) wheel[w] = '{1'b0, '0, '0};
        moving_now   = 1'b0;
        target_edges = '0;
        slave_pwr    = '0;
        last_fix_us  = '0;
    endtask

    // Count a rising edge of one wheel's thresholded reading.
    function automatic void count_rise(int w, logic [SAMPLE_BITS-1:0] rd);
        logic lvl;
        lvl = rd > thr_cfg;
        if (lvl && !wheel[w].hi) begin
            wheel[w].win = wheel[w].win + 1'b1;
            if (wheel[w].tot != '1) wheel[w].tot = wheel[w].tot + 1'b1;
        end
        wheel[w].hi = lvl;
    endfunction

    // Advance the model by one accepted item and return the drive command it gives.
    function automatic t_esdb_result drive_response(logic op, logic [DIST_W-1:0] req_len,
                                                    logic [SAMPLE_BITS-1:0] rd_a,
                                                    logic [SAMPLE_BITS-1:0] rd_b,
                                                    logic [TIME_W-1:0] now);
        t_esdb_result res;
        logic [31:0]  quot;
        int           diff;
        int           pwr;
        res = '0;
        if (op == OP_START) begin
            quot = '0;
            if (req_len >= MIN_DIST && req_len >= margin_cfg) begin
                quot = 32'(req_len - margin_cfg) * 32'(cpr_cfg);
                quot = (circ_cfg == '0) ? 32'hFFFF : quot / 32'(circ_cfg);
                if (quot > 32'hFFFF) quot = 32'hFFFF;
            end
            target_edges = quot[CNT_W-1:0];
            moving_now   = 1'b1;
            for (int w = 0; w < 2; w++) wheel[w] = '{1'b0, '0, '0};
            slave_pwr    = (speed_cfg >= SPEED_OFFSET) ? speed_cfg - SPEED_OFFSET : '0;
            last_fix_us  = now;
            res.master_speed_set = 1'b1;
            res.master_drive     = DRV_W'(0) - DRV_W'(speed_cfg);
            res.slave_speed_set  = 1'b1;
            res.slave_drive      = DRV_W'(0) - DRV_W'(slave_pwr);
            return res;
        end
        // Polls outside a move leave everything untouched.
        if (!moving_now) return res;

        count_rise(MASTER, rd_a);
        res.master_brake = (wheel[MASTER].tot == target_edges);
        count_rise(SLAVE, rd_b);
        if (wheel[SLAVE].tot == target_edges) begin
            res.slave_brake = 1'b1;
        end else if (wheel[SLAVE].tot < target_edges) begin
            if (slave_pwr < MIN_SLAVE_POWER) slave_pwr = MIN_SLAVE_POWER;
            res.slave_speed_set = 1'b1;
            res.slave_drive     = DRV_W'(0) - DRV_W'(slave_pwr);
        end

        if (TIME_W'(now - last_fix_us) > interval_cfg) begin
            diff = int'(wheel[MASTER].win) - int'(wheel[SLAVE].win);
            pwr  = int'(slave_pwr) + diff / 2;
            if (pwr < 0) pwr = 0;
            if (pwr > 127) pwr = 127;
            slave_pwr = PWR_W'(pwr);
            wheel[MASTER].win = '0;
            wheel[SLAVE].win  = '0;
            last_fix_us = now;
            fixes_done++;
        end

        if (wheel[MASTER].tot > target_edges && wheel[SLAVE].tot > target_edges) begin
            moving_now   = 1'b0;
            res.done_res = 1'b1;
            moves_done++;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Present one item, idling beforehand as the current phase asks, and
    // record its expected result once the block takes it.
    task automatic send_item(logic op, logic [DIST_W-1:0] req_len,
                             logic [SAMPLE_BITS-1:0] rd_a, logic [SAMPLE_BITS-1:0] rd_b,
                             logic [TIME_W-1:0] now);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_DATA_W'({now, rd_b, rd_a, req_len});
        do @(posedge i_clk); while (!s_axis_tready);
        expected_drive_q.push_back(drive_response(op, req_len, rd_a, rd_b, now));
        items_sent++;
    endtask

    // Hold the input side until every expected result item has arrived and
    // the block is ready again (target setup finished).
    task automatic wait_results();
        if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
        while (expected_drive_q.size() != 0 || !s_axis_tready) @(posedge i_clk);
    endtask

    task automatic queue_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] val);
        t_reg_write wr;
        wr.idx = idx;
        wr.val = val;
        reg_write_q.push_back(wr);
    endtask

    // Drain the block, then write all queued registers back to back.
    task automatic apply_regs();
        t_reg_write wr;
        wait_results();
        while (reg_write_q.size() != 0) begin
            wr = reg_write_q.pop_front();
            psel    <= 1'b1;
            pwrite  <= 1'b1;
            penable <= 1'b0;
            paddr   <= {wr.idx, 2'b00};
            pwdata  <= wr.val;
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            case (wr.idx)
                REG_ADC_THRESHOLD:   thr_cfg      = wr.val[THR_W-1:0];
                REG_MASTER_SPEED:    speed_cfg    = wr.val[PWR_W-1:0];
                REG_STOP_MARGIN:     margin_cfg   = wr.val[DIST_W-1:0];
                REG_COUNTS_PER_REV:  cpr_cfg      = wr.val[CNT_W-1:0];
                REG_CIRCUMFERENCE:   circ_cfg     = wr.val[CNT_W-1:0];
                REG_UPDATE_INTERVAL: interval_cfg = wr.val[TIME_W-1:0];
                default: ;
            endcase
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Pick an encoder reading on the wanted side of the threshold.
    function automatic logic [SAMPLE_BITS-1:0] level_reading(bit hi);
        if (hi && thr_cfg != '1)
            return SAMPLE_BITS'($urandom_range(4095, int'(thr_cfg) + 1));
        return SAMPLE_BITS'($urandom_range(int'(thr_cfg), 0));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        int k;
        // Poll while idle with every field at its top: all-zero result.
        send_item(OP_SAMPLE, '1, '1, '1, '1);
        // Reset settings: 65535 * 800 / 200 overflows the target, saturate it.
        send_item(OP_START, '1, '0, '0, '1);
        // Short distance while moving: restart with a zero target; one rising
        // edge on each wheel then finishes the move.
        send_item(OP_START, MIN_DIST - 1'b1, '1, '1, 32'd5);
        send_item(OP_SAMPLE, '0, '1, '1, 32'd6);

        // Margin above distance, master speed below the offset, zero threshold,
        // zero interval, and a write past the register list.
        queue_reg(REG_STOP_MARGIN, 32'hFFFF);
        queue_reg(REG_MASTER_SPEED, 32'd3);
        queue_reg(REG_ADC_THRESHOLD, 32'd0);
        queue_reg(REG_UPDATE_INTERVAL, 32'd0);
        queue_reg(REG_SPARE, '1);
        apply_regs();
        send_item(OP_START, 16'd100, '0, '0, 32'd100);
        // Both totals sit on the zero target: brake both; time moved, so correct.
        send_item(OP_SAMPLE, '0, '0, '0, 32'd101);
        // Same time: no correction even with a zero interval.
        send_item(OP_SAMPLE, '0, 12'd1, '0, 32'd101);
        send_item(OP_SAMPLE, '0, 12'd1, 12'd1, 32'd102);

        // Zero circumference gives the all-ones target.
        queue_reg(REG_STOP_MARGIN, 32'd0);
        queue_reg(REG_COUNTS_PER_REV, 32'd1);
        queue_reg(REG_CIRCUMFERENCE, 32'd0);
        queue_reg(REG_MASTER_SPEED, 32'd127);
        apply_regs();
        send_item(OP_START, MIN_DIST, '1, '0, 32'hFFFF_FFF0);
        // Elapsed time wraps through zero.
        send_item(OP_SAMPLE, '0, '1, '0, 32'h0000_0004);
        send_item(OP_START, '0, '0, '1, 32'd10);
        send_item(OP_SAMPLE, '1, '0, '1, 32'd10);

        // Top threshold: nothing ever reads high. Largest exact quotient.
        queue_reg(REG_ADC_THRESHOLD, 32'hFFF);
        queue_reg(REG_COUNTS_PER_REV, 32'hFFFF);
        queue_reg(REG_CIRCUMFERENCE, 32'hFFFF);
        queue_reg(REG_UPDATE_INTERVAL, '1);
        apply_regs();
        send_item(OP_START, '1, '1, '1, 32'd0);
        send_item(OP_SAMPLE, '0, '1, '1, 32'hFFFF_FFFF);

        // Minimum speed gives zero slave power, then the floor lifts it; an
        // interval of one corrects on every poll two microseconds apart.
        queue_reg(REG_ADC_THRESHOLD, 32'd2048);
        queue_reg(REG_COUNTS_PER_REV, 32'd1);
        queue_reg(REG_CIRCUMFERENCE, 32'd1);
        queue_reg(REG_MASTER_SPEED, 32'd5);
        queue_reg(REG_UPDATE_INTERVAL, 32'd1);
        apply_regs();
        send_item(OP_START, 16'd12, '0, '0, 32'd1000);
        for (k = 0; k < 8; k++)
            send_item(OP_SAMPLE, '0, (k % 2 == 0) ? 12'hFFF : 12'h000,
                      (k % 4 == 0) ? 12'hFFF : 12'h000, 32'd1002 + 32'(2 * k));
    endtask

    // Random moves: mostly well-formed edge trains with small targets, some
    // noise polls, huge distances, restarts and register changes between moves.
    task automatic test_random(int n_items);
        int                stop_at;
        int                steps;
        int                flip_a;
        int                flip_b;
        int                k;
        bit                lvl_a;
        bit                lvl_b;
        logic [DIST_W-1:0] req_len;
        stop_at = items_sent + n_items;
        queue_reg(REG_STOP_MARGIN, 32'd0);
        queue_reg(REG_COUNTS_PER_REV, 32'd1);
        queue_reg(REG_CIRCUMFERENCE, 32'd1);
        queue_reg(REG_UPDATE_INTERVAL, 32'd30);
        apply_regs();
        while (items_sent < stop_at) begin
            if ($urandom_range(3) == 0) begin
                case ($urandom_range(5))
                    0: queue_reg(REG_ADC_THRESHOLD, $urandom_range(4095));
                    1: queue_reg(REG_MASTER_SPEED, $urandom_range(127, 5));
                    2: queue_reg(REG_STOP_MARGIN, $urandom_range(40));
                    3: queue_reg(REG_COUNTS_PER_REV, $urandom_range(2, 1));
                    4: queue_reg(REG_CIRCUMFERENCE, $urandom_range(2, 1));
                    default: queue_reg(REG_UPDATE_INTERVAL, $urandom_range(60));
                endcase
                apply_regs();
            end else if ($urandom_range(7) == 0) begin
                wait_results();
            end

            if ($urandom_range(6) == 0) req_len = DIST_W'($urandom);
            else req_len = DIST_W'(int'(margin_cfg) + $urandom_range(30));
            send_item(OP_START, req_len, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                      now_us);

            steps  = 2 * int'(target_edges) + $urandom_range(12);
            if (steps > 150) steps = 150;
            flip_a = $urandom_range(100, 40);
            flip_b = $urandom_range(100, 40);
            lvl_a  = 1'b0;
            lvl_b  = 1'b0;
            for (k = 0; k < steps; k++) begin
                // Leave soon after the move finishes; a few idle polls remain.
                if (!moving_now && $urandom_range(3) != 0) break;
                if ($urandom_range(49) == 0) now_us = $urandom;
                else now_us = now_us + $urandom_range(20);
                if ($urandom_range(19) == 0) begin
                    send_item(OP_SAMPLE, DIST_W'($urandom), SAMPLE_BITS'($urandom),
                              SAMPLE_BITS'($urandom), now_us);
                end else begin
                    if ($urandom_range(99) < flip_a) lvl_a = !lvl_a;
                    if ($urandom_range(99) < flip_b) lvl_b = !lvl_b;
                    send_item(OP_SAMPLE, DIST_W'($urandom), level_reading(lvl_a),
                              level_reading(lvl_b), now_us);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        reset_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();

        test_random(120);
        send_idle_pct = 72;
        test_random(120);
        send_idle_pct = 0;
        stall_pct     = 72;
        test_random(120);
        send_idle_pct = 28;
        stall_pct     = 28;
        test_random(120);

        wait_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Run covered %0d items (directed corner cases, random moves under four",
                 items_sent);
        $display("idle patterns) and %0d results, %0d finished moves, %0d corrections.",
                 results_seen, moves_done, fixes_done);
        if (err_count == 0 && expected_drive_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: stall at random as the phase asks
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------------
    // Result check: compare every taken result with the oldest expectation
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_esdb_result got;
        t_esdb_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_esdb_result'(m_axis_tdata[OUT_RAW_W-1:0]);
            results_seen++;
            if (expected_drive_q.size() == 0) begin
                $error("result item with nothing expected: tdata %h", m_axis_tdata);
                err_count++;
            end else begin
                want = expected_drive_q.pop_front();
                check_field("master_speed_set", want.master_speed_set, got.master_speed_set);
                check_field("master_drive", $signed(want.master_drive),
                            $signed(got.master_drive));
                check_field("slave_speed_set", want.slave_speed_set, got.slave_speed_set);
                check_field("slave_drive", $signed(want.slave_drive), $signed(got.slave_drive));
                check_field("master_brake", want.master_brake, got.master_brake);
                check_field("slave_brake", want.slave_brake, got.slave_brake);
                check_field("done_res", want.done_res, got.done_res);
                check_field("tdata padding", 0, m_axis_tdata[OUT_DATA_W-1:OUT_RAW_W]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run after too long without any handshake
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
